// File: sv/aspect_fit_letterbox_rect_assert.svh
// assertion macros shared by the letterbox fit pipeline modules
// expects i_clk and i_rst_n in the scope of the module that includes it
`ifndef ASPECT_FIT_LETTERBOX_RECT_ASSERT_SVH
`define ASPECT_FIT_LETTERBOX_RECT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define AFL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("afl: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define AFL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("afl: next-cycle check failed");

`endif

// File: sv/afl_pkg.sv
// shared constants and types for the aspect fit letterbox pipeline
// no dependencies
`default_nettype none

package afl_pkg;

    localparam int AFL_DIM_BITS    = 16;
    localparam int AFL_FIELD_W     = 16;
    localparam int AFL_DIV_STEP    = 2;
    localparam int AFL_MATCH_SCALE = 100;
    localparam int AFL_OUT_W       = ((4 * AFL_FIELD_W + 1 + 7) / 8) * 8;

    typedef enum logic [1:0] {
        FIT_EMPTY,
        FIT_FULL,
        FIT_LETTER,
        FIT_PILLAR
    } t_fit_mode;

    typedef struct packed {
        t_fit_mode mode;
        logic      match;
    } t_fit_ctl;

endpackage

`default_nettype wire

// File: sv/aspect_fit_letterbox_rect.sv
// Centered aspect-preserving fit of a source size inside a window, one request per clock.
// Each request carries window and source sizes; the result is the letterboxed or pillarboxed
// rectangle (offset and size) plus a flag set when the two aspects agree within one percent.
// Three front stages form the cross products, classify the fit and evaluate the match flag,
// the pipelined restoring divider retires two quotient bits per stage, and three back stages
// round, clamp and center. A new request is taken every clock while the output is drained;
// under output backpressure empty stages keep filling until the pipeline is full, and
// s_axis_tready follows m_axis_tready combinationally through the valid chain. There is no
// state between requests.
// depends on afl_pkg, afl_front, afl_div, afl_back
`default_nettype none

module aspect_fit_letterbox_rect #(
    parameter int DIM_BITS = afl_pkg::AFL_DIM_BITS
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // window_width, window_height, source_width, source_height, zero pad
    input  logic [((4*DIM_BITS+7)/8)*8-1:0]          i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  logic                                     i_m_axis_tready,
    // rect_x, rect_y, rect_width, rect_height, aspect_match, zero pad
    output logic [afl_pkg::AFL_OUT_W-1:0]            o_m_axis_tdata
);
    import afl_pkg::*;

    logic                       w_f_valid, w_f_ready;
    logic [2*DIM_BITS-1:0]      w_f_num;
    logic [DIM_BITS-1:0]        w_f_den, w_f_ww, w_f_wh;
    t_fit_ctl                   w_f_ctl;

    logic                       w_d_valid, w_d_ready;
    logic [DIM_BITS-1:0]        w_d_quo, w_d_rem, w_d_den, w_d_ww, w_d_wh;
    t_fit_ctl                   w_d_ctl;

    logic [AFL_FIELD_W-1:0]     w_x, w_y, w_w, w_h;
    logic                       w_match;

    afl_front #(
        .DIM_BITS (DIM_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_ww    (i_s_axis_tdata[DIM_BITS-1:0]),
        .i_wh    (i_s_axis_tdata[2*DIM_BITS-1 -: DIM_BITS]),
        .i_sw    (i_s_axis_tdata[3*DIM_BITS-1 -: DIM_BITS]),
        .i_sh    (i_s_axis_tdata[4*DIM_BITS-1 -: DIM_BITS]),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_num   (w_f_num),
        .o_den   (w_f_den),
        .o_ww    (w_f_ww),
        .o_wh    (w_f_wh),
        .o_ctl   (w_f_ctl)
    );

    afl_div #(
        .DIM_BITS (DIM_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_num   (w_f_num),
        .i_den   (w_f_den),
        .i_ww    (w_f_ww),
        .i_wh    (w_f_wh),
        .i_ctl   (w_f_ctl),
        .o_valid (w_d_valid),
        .i_ready (w_d_ready),
        .o_quo   (w_d_quo),
        .o_rem   (w_d_rem),
        .o_den   (w_d_den),
        .o_ww    (w_d_ww),
        .o_wh    (w_d_wh),
        .o_ctl   (w_d_ctl)
    );

    afl_back #(
        .DIM_BITS (DIM_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d_valid),
        .o_ready (w_d_ready),
        .i_quo   (w_d_quo),
        .i_rem   (w_d_rem),
        .i_den   (w_d_den),
        .i_ww    (w_d_ww),
        .i_wh    (w_d_wh),
        .i_ctl   (w_d_ctl),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_x     (w_x),
        .o_y     (w_y),
        .o_w     (w_w),
        .o_h     (w_h),
        .o_match (w_match)
    );

    assign o_m_axis_tdata = AFL_OUT_W'({w_match, w_h, w_w, w_y, w_x});

endmodule

`default_nettype wire

// File: sv/afl_front.sv
// front stages: cross products, fit classification, divide operands, match flag
// depends on afl_pkg
`default_nettype none
`include "aspect_fit_letterbox_rect_assert.svh"

module afl_front #(
    parameter int DIM_BITS = afl_pkg::AFL_DIM_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [DIM_BITS-1:0]       i_ww,
    input  logic [DIM_BITS-1:0]       i_wh,
    input  logic [DIM_BITS-1:0]       i_sw,
    input  logic [DIM_BITS-1:0]       i_sh,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [2*DIM_BITS-1:0]     o_num,
    output logic [DIM_BITS-1:0]       o_den,
    output logic [DIM_BITS-1:0]       o_ww,
    output logic [DIM_BITS-1:0]       o_wh,
    output afl_pkg::t_fit_ctl         o_ctl
);
    import afl_pkg::*;

    localparam int PW = 2 * DIM_BITS;
    localparam int SW = PW + 7;

    logic                 w_rdy_1, w_rdy_2, w_rdy_3;

    logic                 r_1_v;
    logic [DIM_BITS-1:0]  r_1_ww, r_1_wh, r_1_sw, r_1_sh;
    logic [PW-1:0]        r_1_a, r_1_b;
    logic [PW-1:0]        n_1_a, n_1_b;

    logic                 r_2_v;
    t_fit_mode            r_2_mode, n_2_mode;
    logic [PW-1:0]        r_2_num, n_2_num;
    logic [DIM_BITS-1:0]  r_2_den, n_2_den;
    logic [DIM_BITS-1:0]  r_2_ww, r_2_wh;
    logic [PW-1:0]        r_2_diff, n_2_diff;
    logic [PW-1:0]        r_2_big, n_2_big;
    logic                 r_2_nz, n_2_nz;

    logic                 r_3_v;
    t_fit_ctl             r_3_ctl, n_3_ctl;
    logic [PW-1:0]        r_3_num;
    logic [DIM_BITS-1:0]  r_3_den, r_3_ww, r_3_wh;

    logic                 w_win_empty, w_src_empty, w_a_gt;

    assign w_rdy_3 = !r_3_v || i_ready;
    assign w_rdy_2 = !r_2_v || w_rdy_3;
    assign w_rdy_1 = !r_1_v || w_rdy_2;
    assign o_ready = w_rdy_1;

    // stage 1: cross products
    assign n_1_a = PW'(i_ww) * PW'(i_sh);
    assign n_1_b = PW'(i_sw) * PW'(i_wh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_1_v <= 1'b0;
        end else if (w_rdy_1) begin
            r_1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_1 && i_valid) begin
            r_1_ww <= i_ww;
            r_1_wh <= i_wh;
            r_1_sw <= i_sw;
            r_1_sh <= i_sh;
            r_1_a  <= n_1_a;
            r_1_b  <= n_1_b;
        end
    end

    // stage 2: classify and pick the divide operands
    assign w_win_empty = (r_1_ww == '0) || (r_1_wh == '0);
    assign w_src_empty = (r_1_sw == '0) || (r_1_sh == '0);
    assign w_a_gt      = r_1_a > r_1_b;

    always_comb begin
        if (w_win_empty) begin
            n_2_mode = FIT_EMPTY;
        end else if (w_src_empty || (r_1_a == r_1_b)) begin
            n_2_mode = FIT_FULL;
        end else if (!w_a_gt) begin
            n_2_mode = FIT_LETTER;
        end else begin
            n_2_mode = FIT_PILLAR;
        end

        n_2_num = r_1_b;
        n_2_den = DIM_BITS'(1);
        if (n_2_mode == FIT_LETTER) begin
            n_2_num = r_1_a;
            n_2_den = r_1_sw;
        end else if (n_2_mode == FIT_PILLAR) begin
            n_2_den = r_1_sh;
        end

        n_2_diff = w_a_gt ? (r_1_a - r_1_b) : (r_1_b - r_1_a);
        n_2_big  = w_a_gt ? r_1_a : r_1_b;
        n_2_nz   = !w_win_empty && !w_src_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_2_v <= 1'b0;
        end else if (w_rdy_2) begin
            r_2_v <= r_1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_2 && r_1_v) begin
            r_2_mode <= n_2_mode;
            r_2_num  <= n_2_num;
            r_2_den  <= n_2_den;
            r_2_ww   <= r_1_ww;
            r_2_wh   <= r_1_wh;
            r_2_diff <= n_2_diff;
            r_2_big  <= n_2_big;
            r_2_nz   <= n_2_nz;
        end
    end

    // stage 3: within one percent means 100 * diff <= larger product
    always_comb begin
        n_3_ctl.mode  = r_2_mode;
        n_3_ctl.match = r_2_nz &&
                        ((SW'(r_2_diff) * SW'(AFL_MATCH_SCALE)) <= SW'(r_2_big));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_3_v <= 1'b0;
        end else if (w_rdy_3) begin
            r_3_v <= r_2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_3 && r_2_v) begin
            r_3_ctl <= n_3_ctl;
            r_3_num <= r_2_num;
            r_3_den <= r_2_den;
            r_3_ww  <= r_2_ww;
            r_3_wh  <= r_2_wh;
        end
    end

    assign o_valid = r_3_v;
    assign o_num   = r_3_num;
    assign o_den   = r_3_den;
    assign o_ww    = r_3_ww;
    assign o_wh    = r_3_wh;
    assign o_ctl   = r_3_ctl;

    `AFL_ASSERT_NOW(a_match_needs_window, r_3_v && r_3_ctl.match, r_3_ctl.mode != FIT_EMPTY)
    `AFL_ASSERT_NOW(a_den_nonzero, r_3_v, r_3_den != '0)

endmodule

`default_nettype wire

// File: sv/afl_div.sv
// pipelined restoring divider, a fixed number of quotient bits per stage
// depends on afl_pkg; carries window size and fit control alongside
`default_nettype none
`include "aspect_fit_letterbox_rect_assert.svh"

module afl_div #(
    parameter int DIM_BITS = afl_pkg::AFL_DIM_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [2*DIM_BITS-1:0]     i_num,
    input  logic [DIM_BITS-1:0]       i_den,
    input  logic [DIM_BITS-1:0]       i_ww,
    input  logic [DIM_BITS-1:0]       i_wh,
    input  afl_pkg::t_fit_ctl         i_ctl,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [DIM_BITS-1:0]       o_quo,
    output logic [DIM_BITS-1:0]       o_rem,
    output logic [DIM_BITS-1:0]       o_den,
    output logic [DIM_BITS-1:0]       o_ww,
    output logic [DIM_BITS-1:0]       o_wh,
    output afl_pkg::t_fit_ctl         o_ctl
);
    import afl_pkg::*;

    localparam int NSTG = (DIM_BITS + AFL_DIV_STEP - 1) / AFL_DIV_STEP;
    localparam int QB   = NSTG * AFL_DIV_STEP;
    localparam int PW   = DIM_BITS + QB;

    logic [PW-1:0]        w_pad;
    logic [NSTG:0]        w_rdy;
    logic [NSTG-1:0]      w_v_in;
    logic [DIM_BITS-1:0]  w_rem_in [NSTG];
    logic [QB-1:0]        w_ql_in  [NSTG];
    logic [DIM_BITS-1:0]  w_den_in [NSTG];
    logic [DIM_BITS-1:0]  w_ww_in  [NSTG];
    logic [DIM_BITS-1:0]  w_wh_in  [NSTG];
    t_fit_ctl             w_ctl_in [NSTG];

    logic [DIM_BITS-1:0]  n_rem [NSTG];
    logic [QB-1:0]        n_ql  [NSTG];

    logic [NSTG-1:0]      r_v;
    logic [DIM_BITS-1:0]  r_rem [NSTG];
    // low dividend bits shift out the top while quotient bits shift in below
    logic [QB-1:0]        r_ql  [NSTG];
    logic [DIM_BITS-1:0]  r_den [NSTG];
    logic [DIM_BITS-1:0]  r_ww  [NSTG];
    logic [DIM_BITS-1:0]  r_wh  [NSTG];
    t_fit_ctl             r_ctl [NSTG];

    assign w_pad       = PW'(i_num);
    assign w_rdy[NSTG] = i_ready;
    assign o_ready     = w_rdy[0];

    for (genvar g = 0; g < NSTG; g++) begin : g_stg
        if (g == 0) begin : g_first
            assign w_v_in[g]   = i_valid;
            assign w_rem_in[g] = w_pad[PW-1:QB];
            assign w_ql_in[g]  = w_pad[QB-1:0];
            assign w_den_in[g] = i_den;
            assign w_ww_in[g]  = i_ww;
            assign w_wh_in[g]  = i_wh;
            assign w_ctl_in[g] = i_ctl;
        end else begin : g_next
            assign w_v_in[g]   = r_v[g-1];
            assign w_rem_in[g] = r_rem[g-1];
            assign w_ql_in[g]  = r_ql[g-1];
            assign w_den_in[g] = r_den[g-1];
            assign w_ww_in[g]  = r_ww[g-1];
            assign w_wh_in[g]  = r_wh[g-1];
            assign w_ctl_in[g] = r_ctl[g-1];
        end

        assign w_rdy[g] = !r_v[g] || w_rdy[g+1];

        always_comb begin : p_step
            logic [DIM_BITS:0]   v_t;
            logic [DIM_BITS-1:0] v_rem;
            logic [QB-1:0]       v_ql;
            v_rem = w_rem_in[g];
            v_ql  = w_ql_in[g];
            v_t   = '0;
            for (int j = 0; j < AFL_DIV_STEP; j++) begin
                v_t  = {v_rem, v_ql[QB-1]};
                v_ql = {v_ql[QB-2:0], 1'b0};
                if (v_t >= {1'b0, w_den_in[g]}) begin
                    v_t     = v_t - {1'b0, w_den_in[g]};
                    v_ql[0] = 1'b1;
                end
                v_rem = v_t[DIM_BITS-1:0];
            end
            n_rem[g] = v_rem;
            n_ql[g]  = v_ql;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (w_rdy[g]) begin
                r_v[g] <= w_v_in[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[g] && w_v_in[g]) begin
                r_rem[g] <= n_rem[g];
                r_ql[g]  <= n_ql[g];
                r_den[g] <= w_den_in[g];
                r_ww[g]  <= w_ww_in[g];
                r_wh[g]  <= w_wh_in[g];
                r_ctl[g] <= w_ctl_in[g];
            end
        end
    end

    // quotient is below the clamp limit in the fit modes, so it fits DIM_BITS
    assign o_valid = r_v[NSTG-1];
    assign o_quo   = r_ql[NSTG-1][DIM_BITS-1:0];
    assign o_rem   = r_rem[NSTG-1];
    assign o_den   = r_den[NSTG-1];
    assign o_ww    = r_ww[NSTG-1];
    assign o_wh    = r_wh[NSTG-1];
    assign o_ctl   = r_ctl[NSTG-1];

    `AFL_ASSERT_NOW(a_rem_start_bound, i_valid && (i_ctl.mode == FIT_LETTER || i_ctl.mode == FIT_PILLAR), w_rem_in[0] < i_den)
    `AFL_ASSERT_NOW(a_letter_quo_bound, o_valid && (o_ctl.mode == FIT_LETTER), r_ql[NSTG-1] < QB'(o_wh))
    `AFL_ASSERT_NOW(a_pillar_quo_bound, o_valid && (o_ctl.mode == FIT_PILLAR), r_ql[NSTG-1] < QB'(o_ww))

endmodule

`default_nettype wire

// File: sv/afl_back.sv
// back stages: half-up rounding, clamp to the window, centering offset
// depends on afl_pkg; the last stage is the output register
`default_nettype none
`include "aspect_fit_letterbox_rect_assert.svh"

module afl_back #(
    parameter int DIM_BITS = afl_pkg::AFL_DIM_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [DIM_BITS-1:0]             i_quo,
    input  logic [DIM_BITS-1:0]             i_rem,
    input  logic [DIM_BITS-1:0]             i_den,
    input  logic [DIM_BITS-1:0]             i_ww,
    input  logic [DIM_BITS-1:0]             i_wh,
    input  afl_pkg::t_fit_ctl               i_ctl,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [afl_pkg::AFL_FIELD_W-1:0] o_x,
    output logic [afl_pkg::AFL_FIELD_W-1:0] o_y,
    output logic [afl_pkg::AFL_FIELD_W-1:0] o_w,
    output logic [afl_pkg::AFL_FIELD_W-1:0] o_h,
    output logic                            o_match
);
    import afl_pkg::*;

    logic                     w_rdy_1, w_rdy_2, w_rdy_3;
    logic [DIM_BITS:0]        w_den_p1;
    logic [DIM_BITS-1:0]      w_half, w_limit;

    logic                     r_1_v;
    logic [DIM_BITS-1:0]      r_1_rnd, n_1_rnd;
    logic [DIM_BITS-1:0]      r_1_ww, r_1_wh;
    t_fit_ctl                 r_1_ctl;

    logic                     r_2_v;
    logic [DIM_BITS-1:0]      r_2_fit, n_2_fit;
    logic [DIM_BITS-1:0]      r_2_ww, r_2_wh;
    t_fit_ctl                 r_2_ctl;

    logic                     r_3_v;
    logic [AFL_FIELD_W-1:0]   r_3_x, r_3_y, r_3_w, r_3_h;
    logic [AFL_FIELD_W-1:0]   n_3_x, n_3_y, n_3_w, n_3_h;
    logic                     r_3_match;

    assign w_rdy_3 = !r_3_v || i_ready;
    assign w_rdy_2 = !r_2_v || w_rdy_3;
    assign w_rdy_1 = !r_1_v || w_rdy_2;
    assign o_ready = w_rdy_1;

    // stage 1: round half up, the remainder is compared with ceil(den / 2)
    assign w_den_p1 = {1'b0, i_den} + (DIM_BITS+1)'(1);
    assign w_half   = w_den_p1[DIM_BITS:1];
    assign n_1_rnd  = i_quo + DIM_BITS'(i_rem >= w_half);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_1_v <= 1'b0;
        end else if (w_rdy_1) begin
            r_1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_1 && i_valid) begin
            r_1_rnd <= n_1_rnd;
            r_1_ww  <= i_ww;
            r_1_wh  <= i_wh;
            r_1_ctl <= i_ctl;
        end
    end

    // stage 2: clamp to between 1 and the window size on the fitted axis
    assign w_limit = (r_1_ctl.mode == FIT_LETTER) ? r_1_wh : r_1_ww;

    always_comb begin
        if (r_1_rnd == '0) begin
            n_2_fit = DIM_BITS'(1);
        end else if (r_1_rnd > w_limit) begin
            n_2_fit = w_limit;
        end else begin
            n_2_fit = r_1_rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_2_v <= 1'b0;
        end else if (w_rdy_2) begin
            r_2_v <= r_1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_2 && r_1_v) begin
            r_2_fit <= n_2_fit;
            r_2_ww  <= r_1_ww;
            r_2_wh  <= r_1_wh;
            r_2_ctl <= r_1_ctl;
        end
    end

    // stage 3: place the rectangle, centered with the spare pixels halved
    always_comb begin
        n_3_x = '0;
        n_3_y = '0;
        n_3_w = '0;
        n_3_h = '0;
        case (r_2_ctl.mode)
            FIT_FULL: begin
                n_3_w = AFL_FIELD_W'(r_2_ww);
                n_3_h = AFL_FIELD_W'(r_2_wh);
            end
            FIT_LETTER: begin
                n_3_w = AFL_FIELD_W'(r_2_ww);
                n_3_h = AFL_FIELD_W'(r_2_fit);
                n_3_y = AFL_FIELD_W'((r_2_wh - r_2_fit) >> 1);
            end
            FIT_PILLAR: begin
                n_3_w = AFL_FIELD_W'(r_2_fit);
                n_3_h = AFL_FIELD_W'(r_2_wh);
                n_3_x = AFL_FIELD_W'((r_2_ww - r_2_fit) >> 1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_3_v <= 1'b0;
        end else if (w_rdy_3) begin
            r_3_v <= r_2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_3 && r_2_v) begin
            r_3_x     <= n_3_x;
            r_3_y     <= n_3_y;
            r_3_w     <= n_3_w;
            r_3_h     <= n_3_h;
            r_3_match <= r_2_ctl.match;
        end
    end

    assign o_valid = r_3_v;
    assign o_x     = r_3_x;
    assign o_y     = r_3_y;
    assign o_w     = r_3_w;
    assign o_h     = r_3_h;
    assign o_match = r_3_match;

    `AFL_ASSERT_NOW(a_fit_nonzero, r_2_v && (r_2_ctl.mode == FIT_LETTER || r_2_ctl.mode == FIT_PILLAR), r_2_fit != '0)
    `AFL_ASSERT_NOW(a_one_axis_offset, r_3_v, r_3_x == '0 || r_3_y == '0)
    `AFL_ASSERT_NEXT(a_out_held, r_3_v && !i_ready, r_3_v)

endmodule

`default_nettype wire
